// ===== rtl/prt_pkg.sv =====
// Shared types, codes and defaults of the protection region table.
package prt_pkg;

   localparam int DEF_MAX_REGIONS = 32;

   // Request modes
   localparam logic [2:0] MODE_MAP    = 3'd0;
   localparam logic [2:0] MODE_SET    = 3'd1;
   localparam logic [2:0] MODE_UNMAP  = 3'd2;
   localparam logic [2:0] MODE_CHECK  = 3'd3;
   localparam logic [2:0] MODE_QUERY  = 3'd4;
   localparam logic [2:0] MODE_FIND   = 3'd5;

   // Result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD      = 3'd1;
   localparam logic [2:0] ST_OUTSIDE  = 3'd2;
   localparam logic [2:0] ST_CONFLICT = 3'd3;
   localparam logic [2:0] ST_DENIED   = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;
   localparam logic [2:0] ST_FULL     = 3'd6;

   // Configuration register indexes
   localparam logic [1:0] CSR_BASE    = 2'd0;
   localparam logic [1:0] CSR_SIZE    = 2'd1;
   localparam logic [1:0] CSR_PAGED   = 2'd2;
   localparam logic [1:0] CSR_PGLOG   = 2'd3;

   localparam logic [4:0] PGLOG_RESET = 5'd12;

   // One table entry
   typedef struct packed {
      logic [63:0] start;
      logic [63:0] len;
      logic [4:0]  rights;
   } prt_entry_type;

   // Sequencer states
   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_PREP  = 14'b00000000000010,
      S_WIN   = 14'b00000000000100,
      S_CHK   = 14'b00000000001000,
      S_RD    = 14'b00000000010000,
      S_EV1   = 14'b00000000100000,
      S_EV2   = 14'b00000001000000,
      S_PU    = 14'b00000010000000,
      S_NX    = 14'b00000100000000,
      S_ENDS  = 14'b00001000000000,
      S_FLUSH = 14'b00010000000000,
      S_FINAL = 14'b00100000000000,
      S_FWIN  = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } prt_state_type;

endpackage

// ===== rtl/prt_table.sv =====
// Two-bank region table memory: one registered read port, one write port.
module prt_table
   import prt_pkg::*;
#(
   parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
   input  logic                               clock,
   input  logic                               rd_en,
   input  logic [$clog2(MAX_REGIONS):0]       rd_addr,
   output prt_entry_type                      rd_data,
   input  logic                               wr_en,
   input  logic [$clog2(MAX_REGIONS):0]       wr_addr,
   input  prt_entry_type                      wr_data
);

   // Bank select is the top address bit, so each bank spans a power of two
   localparam int Depth = 2 ** ($clog2(MAX_REGIONS) + 1);

   prt_entry_type mem_ff [Depth];
   prt_entry_type rd_data_ff;

   // Write the open entry into the shadow bank
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one entry of the active bank
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/prt_window.sv =====
// Two-step check that a range lies inside the configured guest window.
module prt_window
   import prt_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] base,
   input  logic [63:0] size,
   input  logic [63:0] addr,
   input  logic [63:0] len,
   output logic        in_win
);

   logic        below_ff;
   logic [63:0] off_ff;
   logic [63:0] sz_ff;
   logic [63:0] len_ff;
   logic [63:0] room;

   // Saturate the window at the top of the address space
   assign room = ~base;

   // Register offset and window size
   always_ff @(posedge clock) begin
      below_ff <= addr < base;
      off_ff   <= addr - base;
      sz_ff    <= (size > room) ? room : size;
      len_ff   <= len;
   end

   assign in_win = !below_ff && (off_ff < sz_ff) && (len_ff <= sz_ff - off_ff);

endmodule

// ===== rtl/protection_region_table.sv =====
// Top level of the protection region table: request sequencer and merge logic.
//
// Usage: a request item enters on req_ (mode, address, length, rights,
// alignment) and exactly one result item leaves on rsp_ (status, address,
// length, rights). The user must see that registers are written through
// csr_ only while no request is in flight; the block itself does not
// enforce it. Writes are registered. One request is worked at a time.
// Setup passes S_PREP, S_WIN and S_CHK; the request then walks the
// active table bank entry by entry through the single read port of the
// table memory in S_RD, S_EV1, S_EV2 and S_NX. Map, set rights and unmap
// add S_PU, emitting up to three pieces per entry into the merge stage.
// Closing: S_ENDS, S_FLUSH, S_FINAL, S_FWIN (find without a hit), S_OUT.
// Map, set rights and unmap write the merged table into the other bank and
// switch banks only on success, so a failed change leaves the table as it
// was. Check, query and find stop walking once the answer is known.
// Reset empties the table and restores register defaults; no clearing pass
// is needed. The result is held in an output register: a stalled receiver
// holds it, and the next request is taken meanwhile and waits finished
// until the register frees up.
module protection_region_table
   import prt_pkg::*;
#(
   parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // mode, address, length, rights, alignment_log2
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // status, result_address, result_length, result_rights
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int WW = $clog2(MAX_REGIONS + 3);

   prt_state_type st_ff;

   // Configuration
   logic [63:0] base_ff, size_ff;
   logic        paged_ff;
   logic [4:0]  pglog_ff;

   // Request
   logic [2:0]  mode_ff;
   logic [63:0] addr_ff, len_ff, end_ff, cand_ff, cur_ff, amask_ff, e_ff;
   logic [4:0]  rgt_ff;
   logic [5:0]  alog_ff;
   logic        bad_ff, aovf_ff;

   // Table bookkeeping
   logic          act_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic [WW-1:0] wcnt_ff;
   prt_entry_type o_ff;
   logic          o_vld_ff;
   prt_entry_type pc_ff [4];
   logic [3:0]    pc_vld_ff;
   logic          placed_ff, conflict_ff;
   logic          cov_walk_ff, cov_done_ff;
   logic [2:0]    cov_st_ff;
   logic          dec_ff;

   // Result
   logic [2:0]  res_st_ff;
   logic [63:0] res_addr_ff, res_len_ff;
   logic [4:0]  res_rgt_ff;
   logic        rsp_vld_ff;
   logic [135:0] rsp_data_ff;

   // Memory and window signals
   prt_entry_type q;
   logic          rd_en, wr_en;
   logic          in_win;
   logic [63:0]   win_addr;

   // Setup terms
   logic [63:0] pmask, lenr, align, amask;
   logic        round_ovf, is_chg, uses_pg;

   // Entry evaluation terms
   logic [63:0] s, lo, hi;
   logic        holder, ovl;
   logic [4:0]  reqm;

   // Merge push
   logic          push_vld, join_o, pu_last;
   prt_entry_type push_ent;
   logic [3:0]    pc_clr;

   prt_table #(.MAX_REGIONS(MAX_REGIONS)) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr ({act_ff, idx_ff[IW-1:0]}),
      .rd_data (q),
      .wr_en   (wr_en),
      .wr_addr ({~act_ff, wcnt_ff[IW-1:0]}),
      .wr_data (o_ff)
   );

   prt_window u_window (
      .clock  (clock),
      .base   (base_ff),
      .size   (size_ff),
      .addr   (win_addr),
      .len    (len_ff),
      .in_win (in_win)
   );

   assign win_addr   = (st_ff == S_WIN) ? addr_ff : cand_ff;
   assign rd_en      = (st_ff == S_RD);
   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Setup arithmetic
   always_comb begin
      is_chg    = (mode_ff == MODE_MAP) || (mode_ff == MODE_SET) || (mode_ff == MODE_UNMAP);
      uses_pg   = paged_ff && (is_chg || (mode_ff == MODE_FIND));
      pmask     = (64'd1 << pglog_ff) - 64'd1;
      round_ovf = len_ff > ~pmask;
      lenr      = (len_ff + pmask) & ~pmask;
      align     = 64'd1 << alog_ff;
      if (paged_ff && (align < pmask + 64'd1)) begin
         align = pmask + 64'd1;
      end
      amask = align - 64'd1;
   end

   // Entry evaluation terms
   always_comb begin
      s      = q.start;
      holder = (s <= cur_ff) && (cur_ff < e_ff);
      ovl    = !((end_ff <= s) || (addr_ff >= e_ff));
      lo     = (s > addr_ff) ? s : addr_ff;
      hi     = (e_ff < end_ff) ? e_ff : end_ff;
      reqm   = (mode_ff == MODE_CHECK) ? rgt_ff : 5'd0;
   end

   // Pick the next piece to push into the merge stage
   always_comb begin
      push_vld = 1'b0;
      push_ent = pc_ff[0];
      pc_clr   = 4'b0000;
      if (st_ff == S_PU) begin
         priority if (pc_vld_ff[0]) begin
            push_vld = 1'b1; push_ent = pc_ff[0]; pc_clr = 4'b0001;
         end else if (pc_vld_ff[1]) begin
            push_vld = 1'b1; push_ent = pc_ff[1]; pc_clr = 4'b0010;
         end else if (pc_vld_ff[2]) begin
            push_vld = 1'b1; push_ent = pc_ff[2]; pc_clr = 4'b0100;
         end else if (pc_vld_ff[3]) begin
            push_vld = 1'b1; push_ent = pc_ff[3]; pc_clr = 4'b1000;
         end else begin
            pc_clr = 4'b0000;
         end
      end else if (st_ff == S_ENDS && mode_ff == MODE_MAP && !placed_ff) begin
         push_vld = 1'b1;
         push_ent = '{start: addr_ff, len: len_ff, rights: rgt_ff};
      end
      pu_last = (pc_vld_ff & ~pc_clr) == 4'b0000;
      join_o  = o_vld_ff && (o_ff.start + o_ff.len == push_ent.start)
                && (o_ff.rights == push_ent.rights);
      wr_en   = (((push_vld && !join_o) || st_ff == S_FLUSH) && o_vld_ff
                && (wcnt_ff < WW'(MAX_REGIONS)));
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= '0;
         paged_ff <= 1'b0;
         pglog_ff <= PGLOG_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_BASE:  base_ff  <= csr_wdata;
            CSR_SIZE:  size_ff  <= csr_wdata;
            CSR_PAGED: paged_ff <= csr_wdata[0];
            CSR_PGLOG: pglog_ff <= csr_wdata[4:0];
            default:   ;
         endcase
      end
   end

   // Merge stage: extend or emit the open entry
   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE) begin
         o_vld_ff <= 1'b0;
         wcnt_ff  <= '0;
      end else if (push_vld) begin
         if (join_o) begin
            o_ff.len <= o_ff.len + push_ent.len;
         end else begin
            if (o_vld_ff) begin
               wcnt_ff <= wcnt_ff + WW'(1);
            end
            o_ff     <= push_ent;
            o_vld_ff <= 1'b1;
         end
      end else if (st_ff == S_FLUSH && o_vld_ff) begin
         wcnt_ff  <= wcnt_ff + WW'(1);
         o_vld_ff <= 1'b0;
      end
   end

   // Request sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_IDLE;
         act_ff     <= 1'b0;
         count_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         // Drop the result once taken, unless a new one is loaded now
         if (rsp_vld_ff && rsp_tready && (st_ff != S_OUT)) begin
            rsp_vld_ff <= 1'b0;
         end
         unique case (st_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  mode_ff     <= req_tdata[2:0];
                  addr_ff     <= req_tdata[66:3];
                  len_ff      <= req_tdata[130:67];
                  rgt_ff      <= req_tdata[135:131];
                  alog_ff     <= req_tdata[141:136];
                  res_st_ff   <= ST_OK;
                  res_addr_ff <= '0;
                  res_len_ff  <= '0;
                  res_rgt_ff  <= '0;
                  idx_ff      <= '0;
                  pc_vld_ff   <= '0;
                  placed_ff   <= 1'b0;
                  conflict_ff <= 1'b0;
                  cov_walk_ff <= 1'b0;
                  cov_done_ff <= 1'b0;
                  cov_st_ff   <= ST_OK;
                  dec_ff      <= 1'b0;
                  st_ff       <= S_PREP;
               end
            end
            S_PREP: begin
               // Round the length and settle argument errors
               if (uses_pg && !round_ovf) begin
                  len_ff <= lenr;
               end
               if (mode_ff == MODE_FIND) begin
                  bad_ff <= (len_ff == '0) || (paged_ff && round_ovf);
               end else begin
                  bad_ff <= (len_ff == '0) || (paged_ff && (((addr_ff & pmask) != '0)
                            || round_ovf));
               end
               amask_ff <= amask;
               cand_ff  <= (addr_ff > base_ff) ? addr_ff : base_ff;
               st_ff    <= S_WIN;
            end
            S_WIN: begin
               // Align the search start, form the range end
               aovf_ff <= cand_ff > ~amask_ff;
               cand_ff <= (cand_ff + amask_ff) & ~amask_ff;
               end_ff  <= addr_ff + len_ff;
               cur_ff  <= addr_ff;
               st_ff   <= S_CHK;
            end
            S_CHK: begin
               priority if (mode_ff > MODE_FIND) begin
                  res_st_ff <= ST_BAD;
                  st_ff     <= S_OUT;
               end else if ((is_chg || mode_ff == MODE_FIND) && bad_ff) begin
                  res_st_ff <= ST_BAD;
                  st_ff     <= S_OUT;
               end else if ((is_chg || mode_ff == MODE_CHECK) && !in_win) begin
                  res_st_ff <= ST_OUTSIDE;
                  st_ff     <= S_OUT;
               end else if (mode_ff == MODE_FIND && aovf_ff) begin
                  res_st_ff <= ST_NOTFOUND;
                  st_ff     <= S_OUT;
               end else if (count_ff == '0) begin
                  st_ff <= S_ENDS;
               end else begin
                  st_ff <= S_RD;
               end
            end
            S_RD: begin
               st_ff <= S_EV1;
            end
            S_EV1: begin
               e_ff  <= q.start + q.len;
               st_ff <= S_EV2;
            end
            S_EV2: begin
               idx_ff <= idx_ff + CW'(1);
               // Build pieces for the new table
               if (mode_ff == MODE_MAP) begin
                  pc_ff[0]     <= '{start: addr_ff, len: len_ff, rights: rgt_ff};
                  pc_vld_ff[0] <= !placed_ff && (s >= addr_ff);
                  if (!placed_ff && (s >= addr_ff)) begin
                     placed_ff <= 1'b1;
                  end
                  pc_ff[1]       <= q;
                  pc_vld_ff[3:1] <= 3'b001;
                  if ((s < end_ff) && (addr_ff < e_ff)) begin
                     conflict_ff <= 1'b1;
                  end
               end else if (mode_ff == MODE_SET || mode_ff == MODE_UNMAP) begin
                  pc_vld_ff[0] <= 1'b0;
                  if (!ovl) begin
                     pc_ff[1]       <= q;
                     pc_vld_ff[3:1] <= 3'b001;
                  end else begin
                     pc_ff[1] <= '{start: s, len: addr_ff - s, rights: q.rights};
                     pc_ff[2] <= '{start: lo, len: hi - lo, rights: rgt_ff};
                     pc_ff[3] <= '{start: end_ff, len: e_ff - end_ff, rights: q.rights};
                     pc_vld_ff[1] <= s < addr_ff;
                     pc_vld_ff[2] <= mode_ff == MODE_SET;
                     pc_vld_ff[3] <= end_ff < e_ff;
                  end
               end
               // Walk the cover of the range
               if ((mode_ff == MODE_CHECK || mode_ff == MODE_SET || mode_ff == MODE_UNMAP)
                   && !cov_done_ff && (cov_walk_ff || holder)) begin
                  priority if (!holder) begin
                     cov_done_ff <= 1'b1;
                     cov_st_ff   <= ST_NOTFOUND;
                  end else if ((q.rights & reqm) != reqm) begin
                     cov_done_ff <= 1'b1;
                     cov_st_ff   <= ST_DENIED;
                  end else if ((len_ff == '0) || (end_ff <= e_ff)) begin
                     cov_done_ff <= 1'b1;
                     cov_st_ff   <= ST_OK;
                  end else begin
                     cur_ff      <= e_ff;
                     cov_walk_ff <= 1'b1;
                  end
                  if (mode_ff == MODE_CHECK && (!holder || ((q.rights & reqm) != reqm)
                      || (len_ff == '0) || (end_ff <= e_ff))) begin
                     dec_ff <= 1'b1;
                  end
               end
               // Look up the holder
               if (mode_ff == MODE_QUERY && (s <= addr_ff) && (addr_ff < e_ff)) begin
                  dec_ff      <= 1'b1;
                  res_addr_ff <= s;
                  res_len_ff  <= q.len;
                  res_rgt_ff  <= q.rights;
               end
               // Advance the free range search
               if (mode_ff == MODE_FIND && !(e_ff <= cand_ff)) begin
                  priority if ((cand_ff < s) && (len_ff <= s - cand_ff)) begin
                     dec_ff      <= 1'b1;
                     res_addr_ff <= cand_ff;
                  end else if (e_ff > ~amask_ff) begin
                     dec_ff    <= 1'b1;
                     res_st_ff <= ST_NOTFOUND;
                  end else begin
                     cand_ff <= (e_ff + amask_ff) & ~amask_ff;
                  end
               end
               st_ff <= is_chg ? S_PU : S_NX;
            end
            S_PU: begin
               pc_vld_ff <= pc_vld_ff & ~pc_clr;
               if (pu_last) begin
                  st_ff <= S_NX;
               end
            end
            S_NX: begin
               st_ff <= (dec_ff || idx_ff == count_ff) ? S_ENDS : S_RD;
            end
            S_ENDS: begin
               st_ff <= S_FLUSH;
            end
            S_FLUSH: begin
               st_ff <= S_FINAL;
            end
            S_FINAL: begin
               // A find without a hit still has to fit the window
               st_ff <= (mode_ff == MODE_FIND && !dec_ff) ? S_FWIN : S_OUT;
               unique case (mode_ff)
                  MODE_MAP: begin
                     priority if (conflict_ff) begin
                        res_st_ff <= ST_CONFLICT;
                     end else if (wcnt_ff > WW'(MAX_REGIONS)) begin
                        res_st_ff <= ST_FULL;
                     end else begin
                        act_ff   <= ~act_ff;
                        count_ff <= CW'(wcnt_ff);
                     end
                  end
                  MODE_SET, MODE_UNMAP: begin
                     priority if (!cov_done_ff) begin
                        res_st_ff <= ST_NOTFOUND;
                     end else if (cov_st_ff != ST_OK) begin
                        res_st_ff <= cov_st_ff;
                     end else if (wcnt_ff > WW'(MAX_REGIONS)) begin
                        res_st_ff <= ST_FULL;
                     end else begin
                        act_ff   <= ~act_ff;
                        count_ff <= CW'(wcnt_ff);
                     end
                  end
                  MODE_CHECK: begin
                     res_st_ff <= cov_done_ff ? cov_st_ff : ST_NOTFOUND;
                  end
                  MODE_QUERY: begin
                     if (!dec_ff) begin
                        res_st_ff <= ST_NOTFOUND;
                     end
                  end
                  MODE_FIND: begin
                  end
                  default: begin
                     res_st_ff <= ST_BAD;
                  end
               endcase
            end
            S_FWIN: begin
               // Final candidate must fit the window
               if (in_win) begin
                  res_addr_ff <= cand_ff;
               end else begin
                  res_st_ff <= ST_NOTFOUND;
               end
               st_ff <= S_OUT;
            end
            S_OUT: begin
               // Hold until the output register is free
               if (!rsp_vld_ff || rsp_tready) begin
                  rsp_vld_ff  <= 1'b1;
                  rsp_data_ff <= {res_rgt_ff, res_len_ff, res_addr_ff, res_st_ff};
                  st_ff       <= S_IDLE;
               end
            end
            default: begin
               st_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
